### hdl/txs_pkg.sv
`timescale 1ns / 1ps
// Shared widths, opcode and condition codes, and stage types for the execute stage.
package txs_pkg;

   localparam int unsigned OP_W   = 4;
   localparam int unsigned CUR_W  = 10;
   localparam int unsigned IDX_W  = 11;
   localparam int unsigned WORD_W = 32;

   localparam logic [OP_W-1:0] OP_MOVE  = 4'd1;
   localparam logic [OP_W-1:0] OP_ADD   = 4'd3;
   localparam logic [OP_W-1:0] OP_SUB   = 4'd4;
   localparam logic [OP_W-1:0] OP_JUMP  = 4'd6;
   localparam logic [OP_W-1:0] OP_IF    = 4'd7;
   localparam logic [OP_W-1:0] OP_PRINT = 4'd13;
   localparam logic [OP_W-1:0] OP_READ  = 4'd14;

   localparam logic [IDX_W-1:0] CC_EQ = 11'd8;
   localparam logic [IDX_W-1:0] CC_LT = 11'd9;
   localparam logic [IDX_W-1:0] CC_GT = 11'd10;
   localparam logic [IDX_W-1:0] CC_LE = 11'd11;
   localparam logic [IDX_W-1:0] CC_GE = 11'd12;

   // Instruction fields kept for the execute cycle
   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [CUR_W-1:0]         cur;
      logic [IDX_W-1:0]         pa;
      logic [IDX_W-1:0]         pc;
      logic [IDX_W-1:0]         pd;
      logic signed [WORD_W-1:0] rv;
   } instr_type;

   typedef struct packed {
      logic [IDX_W-1:0]         next_index;
      logic                     print_valid;
      logic signed [WORD_W-1:0] print_value;
      logic                     finished;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [WORD_W-1:0] data;
   } wb_type;

   // 1-based target to 0-based index, zero saturates
   function automatic logic [IDX_W-1:0] target_to_index(input logic [IDX_W-1:0] target);
      logic [IDX_W-1:0] idx;
      idx = (target == '0) ? '0 : target - IDX_W'(1);
      return idx;
   endfunction

endpackage

### hdl/txs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module txs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/txs_alu.sv
`timescale 1ns / 1ps
// Execute logic: arithmetic, compare, next index and writeback value for one instruction.
module txs_alu (
   input  txs_pkg::instr_type                 instr,
   input  logic [txs_pkg::WORD_W-1:0]         opnd_x,
   input  logic [txs_pkg::WORD_W-1:0]         opnd_y,
   input  logic [txs_pkg::IDX_W-1:0]          program_length,
   output txs_pkg::rsp_type                   result,
   output txs_pkg::wb_type                    wb
);

   logic                         cond;
   logic [txs_pkg::IDX_W-1:0]    next_index;

   always_comb begin
      unique case (instr.pc)
         txs_pkg::CC_EQ: cond = ($signed(opnd_x) == $signed(opnd_y));
         txs_pkg::CC_LT: cond = ($signed(opnd_x) <  $signed(opnd_y));
         txs_pkg::CC_GT: cond = ($signed(opnd_x) >  $signed(opnd_y));
         txs_pkg::CC_LE: cond = ($signed(opnd_x) <= $signed(opnd_y));
         txs_pkg::CC_GE: cond = ($signed(opnd_x) >= $signed(opnd_y));
         default:        cond = 1'b0;
      endcase
   end

   always_comb begin
      next_index         = {1'b0, instr.cur} + txs_pkg::IDX_W'(1);
      wb.en              = 1'b0;
      wb.data            = opnd_x;
      result.print_valid = 1'b0;
      result.print_value = '0;
      unique case (instr.op)
         txs_pkg::OP_READ: begin
            wb.en   = 1'b1;
            wb.data = instr.rv;
         end
         txs_pkg::OP_MOVE: begin
            wb.en = 1'b1;
         end
         txs_pkg::OP_ADD: begin
            wb.en   = 1'b1;
            wb.data = opnd_x + opnd_y;
         end
         txs_pkg::OP_SUB: begin
            wb.en   = 1'b1;
            wb.data = opnd_x - opnd_y;
         end
         txs_pkg::OP_PRINT: begin
            result.print_valid = 1'b1;
            result.print_value = opnd_x;
         end
         txs_pkg::OP_IF: begin
            // branch when the relation fails
            if (!cond) begin
               next_index = txs_pkg::target_to_index(instr.pd);
            end
         end
         txs_pkg::OP_JUMP: begin
            next_index = txs_pkg::target_to_index(instr.pa);
         end
         default: begin
         end
      endcase
      result.next_index = next_index;
      result.finished   = (next_index >= program_length);
   end

endmodule

### hdl/toy_isa_execute_stage.sv
`timescale 1ns / 1ps
// Execute stage top level: clearing pass, data memory, forwarding and result register.
//
//   channel | ports    | direction | handshake
//   --------+----------+-----------+----------------------------
//   request | req_*    | in        | req_valid / req_ready
//   result  | rsp_*    | out       | rsp_valid / rsp_ready
//   config  | csr_*    | in        | csr_we, no wait
//
// One instruction per cycle sustained while the result side is ready; a request is held in
// the execute register, and its result in the result register that drives rsp_valid.
// Both operand reads are issued at acceptance into two mirrored RAM copies, and the
// writeback of the previous instruction is forwarded from a bypass register.
// After reset a clearing pass zeroes every memory word, with req_ready low.
// A stalled result holds the execute register, which then holds the request side.
module toy_isa_execute_stage #(
   parameter int unsigned MEM_WORDS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [txs_pkg::IDX_W-1:0]           csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [txs_pkg::OP_W-1:0]            req_operation,
   input  logic [txs_pkg::CUR_W-1:0]           req_current_index,
   input  logic [txs_pkg::IDX_W-1:0]           req_param_a,
   input  logic [txs_pkg::IDX_W-1:0]           req_param_b,
   input  logic [txs_pkg::IDX_W-1:0]           req_param_c,
   input  logic [txs_pkg::IDX_W-1:0]           req_param_d,
   input  logic signed [txs_pkg::WORD_W-1:0]   req_read_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [txs_pkg::IDX_W-1:0]           rsp_next_index,
   output logic                                rsp_print_valid,
   output logic signed [txs_pkg::WORD_W-1:0]   rsp_print_value,
   output logic                                rsp_finished
);

   localparam int unsigned AW = $clog2(MEM_WORDS);
   localparam int unsigned WW = txs_pkg::WORD_W;

   logic [txs_pkg::IDX_W-1:0] prog_len_ff, prog_len_in;
   logic                      clr_busy_ff, clr_busy_in;
   logic [AW-1:0]             clr_addr_ff, clr_addr_in;

   logic                      s1_valid_ff, s1_valid_in;
   txs_pkg::instr_type        s1_instr_ff, s1_instr_in;
   logic [AW-1:0]             s1_rd0_addr_ff, s1_rd0_addr_in;
   logic [AW-1:0]             s1_rd1_addr_ff, s1_rd1_addr_in;
   logic [AW-1:0]             s1_wr_addr_ff, s1_wr_addr_in;
   logic                      s1_oor0_ff, s1_oor0_in;
   logic                      s1_oor1_ff, s1_oor1_in;
   logic                      s1_wr_oor_ff, s1_wr_oor_in;

   logic                      fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]             fwd_addr_ff, fwd_addr_in;
   logic [WW-1:0]             fwd_data_ff, fwd_data_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   txs_pkg::rsp_type          rsp_ff, rsp_in;

   logic                      req_acc;
   logic                      s1_adv;
   logic [txs_pkg::IDX_W-1:0] rd0_sel, rd1_sel;
   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic [WW-1:0]             mem_wdata;
   logic [WW-1:0]             ram0_q, ram1_q;
   logic [WW-1:0]             opnd_x, opnd_y;
   txs_pkg::rsp_type          alu_result;
   txs_pkg::wb_type           alu_wb;
   logic                      s1_write;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign req_acc   = req_valid && req_ready;

   // IF and PRINT read param_a on the first port; IF compares against param_b
   assign rd0_sel = (req_operation == txs_pkg::OP_IF || req_operation == txs_pkg::OP_PRINT)
                    ? req_param_a : req_param_b;
   assign rd1_sel = (req_operation == txs_pkg::OP_IF) ? req_param_b : req_param_c;

   assign s1_write  = s1_adv && alu_wb.en && !s1_wr_oor_ff;
   assign mem_we    = clr_busy_ff || s1_write;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : s1_wr_addr_ff;
   assign mem_wdata = clr_busy_ff ? '0 : alu_wb.data;

   txs_ram #(.WIDTH(WW), .DEPTH(MEM_WORDS)) u_ram0 (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (req_acc),
      .rd_addr (AW'(rd0_sel)),
      .rd_data (ram0_q)
   );

   txs_ram #(.WIDTH(WW), .DEPTH(MEM_WORDS)) u_ram1 (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (req_acc),
      .rd_addr (AW'(rd1_sel)),
      .rd_data (ram1_q)
   );

   // bypass holds the latest write, so a hit always carries the current word
   always_comb begin
      if (s1_oor0_ff) begin
         opnd_x = '0;
      end else if (fwd_valid_ff && fwd_addr_ff == s1_rd0_addr_ff) begin
         opnd_x = fwd_data_ff;
      end else begin
         opnd_x = ram0_q;
      end
      if (s1_oor1_ff) begin
         opnd_y = '0;
      end else if (fwd_valid_ff && fwd_addr_ff == s1_rd1_addr_ff) begin
         opnd_y = fwd_data_ff;
      end else begin
         opnd_y = ram1_q;
      end
   end

   txs_alu u_alu (
      .instr          (s1_instr_ff),
      .opnd_x         (opnd_x),
      .opnd_y         (opnd_y),
      .program_length (prog_len_ff),
      .result         (alu_result),
      .wb             (alu_wb)
   );

   always_comb begin
      prog_len_in = csr_we ? csr_wdata : prog_len_ff;

      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(MEM_WORDS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      s1_valid_in    = s1_valid_ff;
      s1_instr_in    = s1_instr_ff;
      s1_rd0_addr_in = s1_rd0_addr_ff;
      s1_rd1_addr_in = s1_rd1_addr_ff;
      s1_wr_addr_in  = s1_wr_addr_ff;
      s1_oor0_in     = s1_oor0_ff;
      s1_oor1_in     = s1_oor1_ff;
      s1_wr_oor_in   = s1_wr_oor_ff;
      if (req_acc) begin
         s1_valid_in     = 1'b1;
         s1_instr_in.op  = req_operation;
         s1_instr_in.cur = req_current_index;
         s1_instr_in.pa  = req_param_a;
         s1_instr_in.pc  = req_param_c;
         s1_instr_in.pd  = req_param_d;
         s1_instr_in.rv  = req_read_value;
         s1_rd0_addr_in  = AW'(rd0_sel);
         s1_rd1_addr_in  = AW'(rd1_sel);
         s1_wr_addr_in   = AW'(req_param_a);
         s1_oor0_in      = (32'(rd0_sel) >= MEM_WORDS);
         s1_oor1_in      = (32'(rd1_sel) >= MEM_WORDS);
         s1_wr_oor_in    = (32'(req_param_a) >= MEM_WORDS);
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      if (s1_write) begin
         fwd_valid_in = 1'b1;
         fwd_addr_in  = s1_wr_addr_ff;
         fwd_data_in  = alu_wb.data;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
         rsp_in       = alu_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_len_ff  <= '0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prog_len_ff  <= prog_len_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_instr_ff    <= s1_instr_in;
      s1_rd0_addr_ff <= s1_rd0_addr_in;
      s1_rd1_addr_ff <= s1_rd1_addr_in;
      s1_wr_addr_ff  <= s1_wr_addr_in;
      s1_oor0_ff     <= s1_oor0_in;
      s1_oor1_ff     <= s1_oor1_in;
      s1_wr_oor_ff   <= s1_wr_oor_in;
      fwd_addr_ff    <= fwd_addr_in;
      fwd_data_ff    <= fwd_data_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_index  = rsp_ff.next_index;
   assign rsp_print_valid = rsp_ff.print_valid;
   assign rsp_print_value = rsp_ff.print_value;
   assign rsp_finished    = rsp_ff.finished;

endmodule

### hdl/txs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the execute stage, bound to the top level.
module txs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                csr_we,
   input logic [txs_pkg::IDX_W-1:0]           csr_wdata,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [txs_pkg::IDX_W-1:0]           rsp_next_index,
   input logic                                rsp_print_valid,
   input logic signed [txs_pkg::WORD_W-1:0]   rsp_print_value,
   input logic                                rsp_finished
);

   logic [txs_pkg::IDX_W-1:0] plen_ff, plen_in;
   logic [1:0]                pend_ff, pend_in;
   logic                      req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      plen_in = csr_we ? csr_wdata : plen_ff;
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 2'd1;
      end else if (!req_acc && rsp_acc) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
         pend_ff <= '0;
      end else begin
         plen_ff <= plen_in;
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_finished == (rsp_next_index >= plen_ff))
      else $error("finished flag disagrees with program length");

   a_print_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_print_valid |-> rsp_print_value == '0)
      else $error("print value nonzero without a print");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without an outstanding transaction");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken before the memory is cleared");

endmodule

bind toy_isa_execute_stage txs_checker u_txs_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the execute stage: queued instruction driver, result monitor.
module tb_top;

   localparam int unsigned MEM_SIZE    = 1024;
   localparam int unsigned MEM_AW      = $clog2(MEM_SIZE);
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned PHASE_ITEMS = 235;
   localparam int unsigned REPORT_MAX  = 10;

   localparam logic [txs_pkg::OP_W-1:0]  OP_NOP_ZERO  = 4'd0;
   localparam logic [txs_pkg::OP_W-1:0]  OP_NOP_TOP   = 4'd15;
   localparam logic [txs_pkg::IDX_W-1:0] CC_UNDEFINED = 11'd0;
   localparam logic [txs_pkg::IDX_W-1:0] FIELD_TOP    = 11'd1024;

   typedef struct packed {
      logic [txs_pkg::OP_W-1:0]   op;
      logic [txs_pkg::CUR_W-1:0]  cur;
      logic [txs_pkg::IDX_W-1:0]  pa;
      logic [txs_pkg::IDX_W-1:0]  pb;
      logic [txs_pkg::IDX_W-1:0]  pc;
      logic [txs_pkg::IDX_W-1:0]  pd;
      logic [txs_pkg::WORD_W-1:0] rv;
   } fetched_instr_type;

   typedef struct packed {
      logic [txs_pkg::IDX_W-1:0]  next_index;
      logic                       print_valid;
      logic [txs_pkg::WORD_W-1:0] print_value;
      logic                       finished;
   } exec_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_we = 1'b0;
   logic [txs_pkg::IDX_W-1:0]         csr_wdata = '0;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [txs_pkg::OP_W-1:0]          req_operation = '0;
   logic [txs_pkg::CUR_W-1:0]         req_current_index = '0;
   logic [txs_pkg::IDX_W-1:0]         req_param_a = '0;
   logic [txs_pkg::IDX_W-1:0]         req_param_b = '0;
   logic [txs_pkg::IDX_W-1:0]         req_param_c = '0;
   logic [txs_pkg::IDX_W-1:0]         req_param_d = '0;
   logic signed [txs_pkg::WORD_W-1:0] req_read_value = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [txs_pkg::IDX_W-1:0]         rsp_next_index;
   logic                              rsp_print_valid;
   logic signed [txs_pkg::WORD_W-1:0] rsp_print_value;
   logic                              rsp_finished;

   fetched_instr_type instr_backlog[$];
   exec_result_type   predicted_results[$];
   fetched_instr_type in_flight;

   logic [txs_pkg::WORD_W-1:0] shadow_mem [MEM_SIZE];
   logic [txs_pkg::IDX_W-1:0]  prog_length = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned cycle_count   = 0;
   int unsigned fail_count    = 0;
   int unsigned instr_count   = 0;
   int unsigned result_count  = 0;
   int unsigned print_count   = 0;
   int unsigned finish_count  = 0;
   int unsigned length_writes = 0;

   toy_isa_execute_stage dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_current_index (req_current_index),
      .req_param_a       (req_param_a),
      .req_param_b       (req_param_b),
      .req_param_c       (req_param_c),
      .req_param_d       (req_param_d),
      .req_read_value    (req_read_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_index    (rsp_next_index),
      .rsp_print_valid   (rsp_print_valid),
      .rsp_print_value   (rsp_print_value),
      .rsp_finished      (rsp_finished)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < MEM_SIZE; i++) shadow_mem[i] = '0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [txs_pkg::WORD_W-1:0] mem_load(
         input logic [txs_pkg::IDX_W-1:0] addr);
      return (addr >= MEM_SIZE) ? '0 : shadow_mem[addr[MEM_AW-1:0]];
   endfunction

   function automatic void mem_store(input logic [txs_pkg::IDX_W-1:0] addr,
                                     input logic [txs_pkg::WORD_W-1:0] data);
      if (addr < MEM_SIZE) shadow_mem[addr[MEM_AW-1:0]] = data;
   endfunction

   function automatic logic [txs_pkg::IDX_W-1:0] jump_dest(
         input logic [txs_pkg::IDX_W-1:0] target);
      return (target == '0) ? '0 : target - 1'b1;
   endfunction

   function automatic exec_result_type execute_instr(input fetched_instr_type it);
      exec_result_type            r;
      logic [txs_pkg::WORD_W-1:0] lhs;
      logic [txs_pkg::WORD_W-1:0] rhs;
      logic                       holds;
      r = '0;
      r.next_index = txs_pkg::IDX_W'(it.cur) + 1'b1;
      case (it.op)
         txs_pkg::OP_READ:  mem_store(it.pa, it.rv);
         txs_pkg::OP_MOVE:  mem_store(it.pa, mem_load(it.pb));
         txs_pkg::OP_ADD:   mem_store(it.pa, mem_load(it.pb) + mem_load(it.pc));
         txs_pkg::OP_SUB:   mem_store(it.pa, mem_load(it.pb) - mem_load(it.pc));
         txs_pkg::OP_PRINT: begin
            r.print_valid = 1'b1;
            r.print_value = mem_load(it.pa);
         end
         txs_pkg::OP_IF: begin
            lhs = mem_load(it.pa);
            rhs = mem_load(it.pb);
            case (it.pc)
               txs_pkg::CC_EQ: holds = (lhs == rhs);
               txs_pkg::CC_LT: holds = ($signed(lhs) <  $signed(rhs));
               txs_pkg::CC_GT: holds = ($signed(lhs) >  $signed(rhs));
               txs_pkg::CC_LE: holds = ($signed(lhs) <= $signed(rhs));
               txs_pkg::CC_GE: holds = ($signed(lhs) >= $signed(rhs));
               default:        holds = 1'b0;
            endcase
            // branch on false
            if (!holds) r.next_index = jump_dest(it.pd);
         end
         txs_pkg::OP_JUMP:  r.next_index = jump_dest(it.pa);
         default:  ;
      endcase
      r.finished = (r.next_index >= prog_length);
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic [txs_pkg::IDX_W-1:0] pick_addr();
      int unsigned roll;
      roll = $urandom_range(99);
      // keep most traffic on a few words so reads see earlier writes
      if (roll < 70)      return txs_pkg::IDX_W'($urandom_range(15));
      else if (roll < 80) return FIELD_TOP;
      else if (roll < 90) return txs_pkg::IDX_W'($urandom_range(1023, 1008));
      else                return txs_pkg::IDX_W'($urandom_range(1024));
   endfunction

   function automatic logic [txs_pkg::IDX_W-1:0] pick_target();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 40)      return txs_pkg::IDX_W'($urandom_range(20));
      else if (roll < 50) return '0;
      else if (roll < 60) return FIELD_TOP;
      else                return txs_pkg::IDX_W'($urandom_range(1024));
   endfunction

   function automatic logic [txs_pkg::WORD_W-1:0] pick_word();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10)      return 32'h7FFF_FFFF;
      else if (roll < 20) return 32'h8000_0000;
      else if (roll < 30) return txs_pkg::WORD_W'($urandom_range(3));
      else if (roll < 35) return '1;
      else                return $urandom;
   endfunction

   function automatic logic [txs_pkg::OP_W-1:0] pick_op();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15)      return txs_pkg::OP_READ;
      else if (roll < 25) return txs_pkg::OP_MOVE;
      else if (roll < 40) return txs_pkg::OP_ADD;
      else if (roll < 55) return txs_pkg::OP_SUB;
      else if (roll < 70) return txs_pkg::OP_PRINT;
      else if (roll < 85) return txs_pkg::OP_IF;
      else if (roll < 92) return txs_pkg::OP_JUMP;
      else                return txs_pkg::OP_W'($urandom_range(15));
   endfunction

   function automatic fetched_instr_type random_instr(
         input logic [txs_pkg::CUR_W-1:0] at_index);
      fetched_instr_type it;
      it.op  = pick_op();
      it.cur = at_index;
      it.pa  = (it.op == txs_pkg::OP_JUMP) ? pick_target() : pick_addr();
      it.pb  = pick_addr();
      it.pc  = pick_addr();
      it.pd  = pick_target();
      it.rv  = pick_word();
      if (it.op == txs_pkg::OP_IF) begin
         it.pc = ($urandom_range(99) < 85)
                 ? txs_pkg::IDX_W'($urandom_range(txs_pkg::CC_GE, txs_pkg::CC_EQ))
                 : txs_pkg::IDX_W'($urandom_range(1024));
      end
      return it;
   endfunction

   task automatic queue_instr(input logic [txs_pkg::OP_W-1:0] op,
                              input logic [txs_pkg::CUR_W-1:0] cur,
                              input logic [txs_pkg::IDX_W-1:0] pa,
                              input logic [txs_pkg::IDX_W-1:0] pb,
                              input logic [txs_pkg::IDX_W-1:0] pc,
                              input logic [txs_pkg::IDX_W-1:0] pd,
                              input logic [txs_pkg::WORD_W-1:0] rv);
      instr_backlog.push_back('{op, cur, pa, pb, pc, pd, rv});
   endtask

   task automatic set_program_length(input logic [txs_pkg::IDX_W-1:0] len);
      csr_we    <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_we      <= 1'b0;
      prog_length  = len;
      length_writes++;
   endtask

   task automatic wait_drained();
      while (instr_backlog.size() != 0 || req_valid || predicted_results.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : instr_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            predicted_results.push_back(execute_instr(in_flight));
            instr_count++;
         end
         if (instr_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            in_flight = instr_backlog.pop_front();
            req_valid         <= 1'b1;
            req_operation     <= in_flight.op;
            req_current_index <= in_flight.cur;
            req_param_a       <= in_flight.pa;
            req_param_b       <= in_flight.pb;
            req_param_c       <= in_flight.pc;
            req_param_d       <= in_flight.pd;
            req_read_value    <= in_flight.rv;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : result_monitor
      exec_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               if (fail_count < REPORT_MAX)
                  $display("ERROR: unexpected result next=%0d print=%0d/%h finished=%0d",
                           rsp_next_index, rsp_print_valid, rsp_print_value, rsp_finished);
               fail_count++;
            end else begin
               want = predicted_results.pop_front();
               result_count++;
               if (want.print_valid) print_count++;
               if (want.finished) finish_count++;
               if (rsp_next_index !== want.next_index || rsp_print_valid !== want.print_valid ||
                   rsp_print_value !== want.print_value || rsp_finished !== want.finished) begin
                  if (fail_count < REPORT_MAX)
                     $display({"ERROR: result %0d mismatch: expected next=%0d print=%0d/%h ",
                               "finished=%0d, got next=%0d print=%0d/%h finished=%0d"},
                              result_count, want.next_index, want.print_valid,
                              want.print_value, want.finished, rsp_next_index,
                              rsp_print_valid, rsp_print_value, rsp_finished);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      logic [txs_pkg::IDX_W-1:0] length_plan [6];
      int unsigned               seq_index;
      length_plan[0] = '0;
      length_plan[1] = txs_pkg::IDX_W'($urandom_range(1023, 2));
      length_plan[2] = 11'd1;
      length_plan[3] = txs_pkg::IDX_W'($urandom_range(1023, 2));
      length_plan[4] = FIELD_TOP;
      length_plan[5] = 11'd1023;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_program_length(FIELD_TOP);
      send_idle_pct = 6;
      recv_idle_pct = 50;

      // wraparound, out-of-range addresses, all relations, zero and max targets
      queue_instr(txs_pkg::OP_READ,  10'd0, 11'd0, 11'd0, 11'd0, 11'd0, 32'h7FFF_FFFF);
      queue_instr(txs_pkg::OP_READ,  10'd1, 11'd1, 11'd0, 11'd0, 11'd0, 32'h8000_0000);
      queue_instr(txs_pkg::OP_READ,  10'd2, 11'd1023, 11'd0, 11'd0, 11'd0, 32'hFFFF_FFFF);
      queue_instr(txs_pkg::OP_READ,  10'd3, FIELD_TOP, 11'd0, 11'd0, 11'd0, 32'h1234_5678);
      queue_instr(txs_pkg::OP_READ,  10'd4, 11'd3, 11'd0, 11'd0, 11'd0, 32'd1);
      queue_instr(txs_pkg::OP_ADD,   10'd5, 11'd2, 11'd0, 11'd3, 11'd0, '0);
      queue_instr(txs_pkg::OP_SUB,   10'd6, 11'd4, 11'd1, 11'd3, 11'd0, '0);
      queue_instr(txs_pkg::OP_MOVE,  10'd7, 11'd5, 11'd1023, 11'd0, 11'd0, '0);
      queue_instr(txs_pkg::OP_MOVE,  10'd8, 11'd1023, FIELD_TOP, 11'd0, 11'd0, '0);
      queue_instr(txs_pkg::OP_PRINT, 10'd9, 11'd2, 11'd0, 11'd0, 11'd0, '0);
      queue_instr(txs_pkg::OP_PRINT, 10'd10, 11'd4, 11'd0, 11'd0, 11'd0, '0);
      queue_instr(txs_pkg::OP_PRINT, 10'd11, FIELD_TOP, 11'd0, 11'd0, 11'd0, '0);
      queue_instr(txs_pkg::OP_IF, 10'd12, 11'd0, 11'd1, txs_pkg::CC_EQ, 11'd1, '0);
      queue_instr(txs_pkg::OP_IF, 10'd13, 11'd1, 11'd0, txs_pkg::CC_LT, FIELD_TOP, '0);
      queue_instr(txs_pkg::OP_IF, 10'd14, 11'd0, 11'd1, txs_pkg::CC_GT, 11'd5, '0);
      queue_instr(txs_pkg::OP_IF, 10'd15, 11'd0, 11'd4, txs_pkg::CC_LE, 11'd0, '0);
      queue_instr(txs_pkg::OP_IF, 10'd16, 11'd1, 11'd2, txs_pkg::CC_GE, 11'd3, '0);
      queue_instr(txs_pkg::OP_IF, 10'd17, 11'd1, 11'd0, txs_pkg::CC_GE, 11'd0, '0);
      queue_instr(txs_pkg::OP_IF, 10'd18, 11'd0, 11'd0, CC_UNDEFINED, 11'd7, '0);
      queue_instr(txs_pkg::OP_IF, 10'd19, 11'd0, 11'd0, FIELD_TOP, FIELD_TOP, '0);
      queue_instr(txs_pkg::OP_JUMP, 10'd20, 11'd0, 11'd0, 11'd0, 11'd0, '0);
      queue_instr(txs_pkg::OP_JUMP, 10'd21, FIELD_TOP, 11'd0, 11'd0, 11'd0, '0);
      queue_instr(OP_NOP_ZERO, 10'd1023, FIELD_TOP, FIELD_TOP, FIELD_TOP, FIELD_TOP, '1);
      queue_instr(OP_NOP_TOP, 10'd22, 11'd5, 11'd6, 11'd7, 11'd8, 32'h5555_AAAA);
      queue_instr(txs_pkg::OP_PRINT, 10'd23, 11'd5, FIELD_TOP, FIELD_TOP, FIELD_TOP, '0);

      seq_index = 0;
      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         set_program_length(length_plan[ph]);
         case (ph / 2)
            0:       begin send_idle_pct = 6;  recv_idle_pct = 50; end
            1:       begin send_idle_pct = 50; recv_idle_pct = 6;  end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // mostly walk through the program, now and then fetch from anywhere
            if (prog_length == 0 || $urandom_range(99) < 20)
               seq_index = $urandom_range(1023);
            else
               seq_index = (seq_index + 1) % prog_length;
            instr_backlog.push_back(random_instr(txs_pkg::CUR_W'(seq_index)));
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (predicted_results.size() != 0) begin
         $display("ERROR: %0d results never arrived", predicted_results.size());
         fail_count++;
      end

      $display("Executed %0d instructions over %0d program lengths; %0d results checked.",
               instr_count, length_writes, result_count);
      $display("Results with a printed word: %0d, with execution finished: %0d, failures: %0d",
               print_count, finish_count, fail_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
